/* sv/gru_pkg.sv */
// ----------------------------------------------------------------------------
// gru_pkg - shared types and constants of the Givens rotation unit
// Operation codes, fixed-point constants and datapath widths.
// ----------------------------------------------------------------------------
`default_nettype none

package gru_pkg;

    typedef logic        [31:0] t_word;
    typedef logic signed [31:0] t_sword;
    typedef logic signed [32:0] t_coef;

    localparam logic OP_GEN   = 1'b0;
    localparam logic OP_APPLY = 1'b1;

    localparam t_sword ONE_Q30  = 32'sh4000_0000;
    localparam t_word  SAT_POS  = 32'h7FFF_FFFF;
    localparam t_word  SAT_NEG  = 32'h8000_0000;

    localparam logic [4:0] CNT_LAST = 5'd31;

endpackage

`default_nettype wire

/* sv/givens_rotation_unit.sv */
// ----------------------------------------------------------------------------
// givens_rotation_unit - bit-serial Givens rotation generate / apply
// Generate: r = isqrt(a^2 + b^2), cos = a/r, sin = b/r (Q2.30), stored.
// Apply: rotate (a, b) with the stored cos/sin, round and saturate.
//
//   channel  direction  handshake                  payload
//   input    in         i_in_valid / o_in_ready    i_operation, i_operand_a/b
//   output   out        o_out_valid / i_out_ready  o_rot_norm, o_cos/sin_value,
//                                                  o_new_a, o_new_b
//
// Generate runs the bit-serial squares, then the two-bit-per-cycle square root,
// then the two parallel restoring divisions and a final quotient rounding step.
// Apply runs the bit-serial multiply steps, then rounding and saturation.
// One item is in flight; the next transfer is taken once the result sits in
// the output register, even while that result waits for i_out_ready.
// Reset is synchronous; it restores the identity rotation and drops o_out_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module givens_rotation_unit
    import gru_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic          i_operation,
    input  wire logic signed [31:0] i_operand_a,
    input  wire logic signed [31:0] i_operand_b,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic        [31:0] o_rot_norm,
    output logic signed [31:0] o_cos_value,
    output logic signed [31:0] o_sin_value,
    output logic signed [31:0] o_new_a,
    output logic signed [31:0] o_new_b
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_SQRT = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_QFIN = 3'd4;
    localparam logic [2:0] S_RND1 = 3'd5;
    localparam logic [2:0] S_RND2 = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    function automatic t_word f_sat(input logic [63:0] mag, input logic neg);
        logic [63:0] rsum;
        logic [33:0] m;
        logic [33:0] mneg;
        rsum = mag + 64'h2000_0000;
        m    = rsum[63:30];
        mneg = 34'd0 - m;
        if (neg) begin
            f_sat = (m > 34'h0_8000_0000) ? SAT_NEG : mneg[31:0];
        end else begin
            f_sat = (m > 34'h0_7FFF_FFFF) ? SAT_POS : m[31:0];
        end
    endfunction

    logic [2:0]  r_state, n_state;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_o_valid;
    t_sword      r_cos, r_sin;

    logic        r_op, r_sa, r_sb;
    t_word       r_ma, r_mb;
    t_word       r_mra, r_mrb;
    t_coef       r_x0, r_y0, r_x1, r_y1;
    logic signed [34:0] r_hi0, r_hi1;
    t_word       r_lo0, r_lo1;
    logic [63:0] r_rad;
    logic [34:0] r_rem;
    t_word       r_root;
    logic [32:0] r_dra, r_drb;
    t_word       r_qa, r_qb;
    logic [63:0] r_mag0, r_mag1;
    logic        r_ng0, r_ng1;
    t_word       r_na, r_nb;
    t_word       r_o_norm, r_o_na, r_o_nb;
    t_sword      r_o_cos, r_o_sin;

    logic        in_xfer, load_out, cnt_last;
    t_word       in_ma, in_mb;
    t_coef       c_ext, s_ext;
    logic signed [35:0] mac0, mac1;
    logic [34:0] rem_sh, trial;
    logic        sq_ge;
    logic [32:0] dt_a, dt_b;
    logic        dv_ge_a, dv_ge_b;
    logic [32:0] qr_a, qr_b;
    t_sword      cos_q, sin_q;
    logic signed [63:0] acc0, acc1;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign load_out = (r_state == S_DONE) && (!r_o_valid || i_out_ready);
    assign cnt_last = (r_cnt == CNT_LAST);

    assign in_ma = i_operand_a[31] ? 32'd0 - i_operand_a : i_operand_a;
    assign in_mb = i_operand_b[31] ? 32'd0 - i_operand_b : i_operand_b;
    assign c_ext = 33'(r_cos);
    assign s_ext = 33'(r_sin);

    // one multiplier bit of each operand per cycle
    assign mac0 = 36'(r_hi0) + (r_mra[0] ? 36'(r_x0) : 36'sd0)
                             + (r_mrb[0] ? 36'(r_y0) : 36'sd0);
    assign mac1 = 36'(r_hi1) + (r_mra[0] ? 36'(r_x1) : 36'sd0)
                             + (r_mrb[0] ? 36'(r_y1) : 36'sd0);

    // square root, two radicand bits per cycle
    assign rem_sh = {r_rem[32:0], r_rad[63:62]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign sq_ge  = (rem_sh >= trial);

    // restoring division, one quotient bit per cycle
    assign dt_a    = (r_cnt == 5'd0) ? r_dra : {r_dra[31:0], 1'b0};
    assign dt_b    = (r_cnt == 5'd0) ? r_drb : {r_drb[31:0], 1'b0};
    assign dv_ge_a = (dt_a >= {1'b0, r_root});
    assign dv_ge_b = (dt_b >= {1'b0, r_root});

    assign qr_a  = ({1'b0, r_qa} + 33'd1) >> 1;
    assign qr_b  = ({1'b0, r_qb} + 33'd1) >> 1;
    assign cos_q = r_sa ? 32'sd0 - $signed(qr_a[31:0]) : $signed(qr_a[31:0]);
    assign sin_q = r_sb ? 32'sd0 - $signed(qr_b[31:0]) : $signed(qr_b[31:0]);

    assign acc0 = $signed({r_hi0[31:0], r_lo0});
    assign acc1 = $signed({r_hi1[31:0], r_lo1});

    always_comb begin
        n_state = r_state;
        n_cnt   = 5'(r_cnt + 5'd1);
        unique case (r_state)
            S_IDLE: begin
                n_cnt = 5'd0;
                if (in_xfer) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (cnt_last) begin
                    n_state = (r_op == OP_GEN) ? S_SQRT : S_RND1;
                end
            end
            S_SQRT: begin
                if (cnt_last) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (cnt_last) begin
                    n_state = S_QFIN;
                end
            end
            S_QFIN: n_state = S_DONE;
            S_RND1: n_state = S_RND2;
            S_RND2: n_state = S_DONE;
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= 5'd0;
            r_o_valid <= 1'b0;
            r_cos     <= ONE_Q30;
            r_sin     <= 32'sd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            if (r_state == S_QFIN) begin
                if (r_root == 32'd0) begin
                    r_cos <= ONE_Q30;
                    r_sin <= 32'sd0;
                end else begin
                    r_cos <= cos_q;
                    r_sin <= sin_q;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    r_op  <= i_operation;
                    r_sa  <= i_operand_a[31];
                    r_sb  <= i_operand_b[31];
                    r_ma  <= in_ma;
                    r_mb  <= in_mb;
                    r_mra <= in_ma;
                    r_mrb <= in_mb;
                    r_hi0 <= 35'sd0;
                    r_hi1 <= 35'sd0;
                    r_lo0 <= 32'd0;
                    r_lo1 <= 32'd0;
                    if (i_operation == OP_GEN) begin
                        r_x0 <= $signed({1'b0, in_ma});
                        r_y0 <= $signed({1'b0, in_mb});
                    end else begin
                        r_x0 <= i_operand_a[31] ? -c_ext : c_ext;
                        r_y0 <= i_operand_b[31] ? -s_ext : s_ext;
                    end
                    r_x1 <= i_operand_a[31] ? s_ext : -s_ext;
                    r_y1 <= i_operand_b[31] ? -c_ext : c_ext;
                end
            end
            S_MUL: begin
                r_hi0 <= mac0[35:1];
                r_hi1 <= mac1[35:1];
                r_lo0 <= {mac0[0], r_lo0[31:1]};
                r_lo1 <= {mac1[0], r_lo1[31:1]};
                r_mra <= r_mra >> 1;
                r_mrb <= r_mrb >> 1;
                if (cnt_last) begin
                    r_rad  <= {mac0[32:0], r_lo0[31:1]};
                    r_rem  <= 35'd0;
                    r_root <= 32'd0;
                end
            end
            S_SQRT: begin
                r_rad  <= {r_rad[61:0], 2'b00};
                r_rem  <= sq_ge ? rem_sh - trial : rem_sh;
                r_root <= {r_root[30:0], sq_ge};
                if (cnt_last) begin
                    r_dra <= {1'b0, r_ma};
                    r_drb <= {1'b0, r_mb};
                end
            end
            S_DIV: begin
                r_dra <= dv_ge_a ? dt_a - {1'b0, r_root} : dt_a;
                r_drb <= dv_ge_b ? dt_b - {1'b0, r_root} : dt_b;
                r_qa  <= {r_qa[30:0], dv_ge_a};
                r_qb  <= {r_qb[30:0], dv_ge_b};
            end
            S_QFIN: begin
            end
            S_RND1: begin
                r_ng0  <= acc0[63];
                r_ng1  <= acc1[63];
                r_mag0 <= acc0[63] ? 64'd0 - acc0 : acc0;
                r_mag1 <= acc1[63] ? 64'd0 - acc1 : acc1;
            end
            S_RND2: begin
                r_na <= f_sat(r_mag0, r_ng0);
                r_nb <= f_sat(r_mag1, r_ng1);
            end
            S_DONE: begin
                if (load_out) begin
                    r_o_cos <= r_cos;
                    r_o_sin <= r_sin;
                    if (r_op == OP_GEN) begin
                        r_o_norm <= r_root;
                        r_o_na   <= 32'd0;
                        r_o_nb   <= 32'd0;
                    end else begin
                        r_o_norm <= 32'd0;
                        r_o_na   <= r_na;
                        r_o_nb   <= r_nb;
                    end
                end
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_rot_norm  = r_o_norm;
    assign o_cos_value = r_o_cos;
    assign o_sin_value = r_o_sin;
    assign o_new_a     = $signed(r_o_na);
    assign o_new_b     = $signed(r_o_nb);

endmodule

`default_nettype wire

/* sv/gru_checker.sv */
// ----------------------------------------------------------------------------
// gru_checker - port-level checks of the Givens rotation unit
// Watches the top-level ports and flags result or handshake slips.
// ----------------------------------------------------------------------------
`default_nettype none

module gru_checker
    import gru_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic        [31:0] o_rot_norm,
    input wire logic signed [31:0] o_cos_value,
    input wire logic signed [31:0] o_sin_value,
    input wire logic signed [31:0] o_new_a,
    input wire logic signed [31:0] o_new_b
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_rot_norm)
            && $stable(o_cos_value) && $stable(o_sin_value)
            && $stable(o_new_a) && $stable(o_new_b))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while an item is in flight");

    a_gen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_rot_norm != 32'd0) |-> (o_new_a == 32'sd0) && (o_new_b == 32'sd0))
        else $error("generate result carries rotated pair");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_cos_value <= ONE_Q30) && (o_cos_value >= -ONE_Q30)
            && (o_sin_value <= ONE_Q30) && (o_sin_value >= -ONE_Q30))
        else $error("cosine or sine beyond unit range");

endmodule

bind givens_rotation_unit gru_checker u_gru_checker (.*);

`default_nettype wire

/* verif/tb_givens_rotation_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_givens_rotation_unit - self-checking bench for the Givens rotation unit
// Walks a table of directed generate/apply items (identity rotation after
// reset, zero pair, most negative and most positive operands, saturation),
// then about 1800 random items with bursty idling on both channels and one long
// output hold-off. Every output transfer is checked field by field against the
// table row's given result, or else against an in-bench fixed-point model.
// ----------------------------------------------------------------------------

module tb_givens_rotation_unit
    import gru_pkg::*;
();

    localparam int RANDOM_ITEMS = 1800;
    localparam int QUIET_TAIL   = 200;
    localparam int CHUNK_ITEMS  = 150;
    localparam int HOLD_AFTER   = 400;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 1_000_000;

    typedef struct packed {
        t_word  norm;
        t_sword cos_q30;
        t_sword sin_q30;
        t_sword rot_a;
        t_sword rot_b;
    } t_rot_res;

    typedef struct packed {
        logic     op;
        t_sword   a;
        t_sword   b;
        logic     known;
        t_rot_res res;
    } t_stim_row;

    localparam t_rot_res NO_RES = '0;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_in_valid;
    logic            o_in_ready;
    logic            i_operation;
    logic signed [31:0] i_operand_a;
    logic signed [31:0] i_operand_b;
    logic            o_out_valid;
    logic            i_out_ready;
    logic     [31:0] o_rot_norm;
    logic signed [31:0] o_cos_value;
    logic signed [31:0] o_sin_value;
    logic signed [31:0] o_new_a;
    logic signed [31:0] o_new_b;

    t_sword    cur_cos;
    t_sword    cur_sin;
    t_rot_res  pending_rotations[$];
    t_stim_row stim_rows[$];
    t_rot_res  want;
    int        n_fail;
    int        n_accepted;
    int        n_cycles;
    int        gap_pct;
    int        stall_pct;
    bit        hold_done;

    givens_rotation_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_rot_norm  (o_rot_norm),
        .o_cos_value (o_cos_value),
        .o_sin_value (o_sin_value),
        .o_new_a     (o_new_a),
        .o_new_b     (o_new_b)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] magnitude(logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] isqrt_floor(logic [63:0] n);
        logic [63:0] rem, root, bitv;
        rem  = n;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // |x| * 2^30 / d, round half away from zero, sign of x
    function automatic t_sword q30_ratio(logic signed [63:0] x, logic [63:0] d);
        logic [63:0] num, q, r;
        num = magnitude(x) << 30;
        q   = ((num << 1) + d) / (d << 1);
        r   = x[63] ? -q : q;
        return r[31:0];
    endfunction

    // Q18.46 to Q16.16, round half away from zero, saturate
    function automatic t_sword round_sat(logic signed [63:0] acc);
        logic [63:0] m, r;
        m = (magnitude(acc) + (64'd1 << 29)) >> 30;
        if (acc[63]) begin
            if (m > 64'h8000_0000) return SAT_NEG;
            r = -m;
            return r[31:0];
        end
        if (m > 64'h7FFF_FFFF) return SAT_POS;
        return m[31:0];
    endfunction

    function automatic t_rot_res predict_rotation(logic op, t_sword a, t_sword b);
        t_rot_res           res;
        logic signed [63:0] a64, b64, c64, s64;
        logic        [63:0] ma, mb, r;
        res = NO_RES;
        a64 = a;
        b64 = b;
        if (op == OP_GEN) begin
            ma = magnitude(a64);
            mb = magnitude(b64);
            r  = isqrt_floor(ma * ma + mb * mb);
            if (r == 0) begin
                cur_cos = ONE_Q30;
                cur_sin = '0;
            end else begin
                cur_cos = q30_ratio(a64, r);
                cur_sin = q30_ratio(b64, r);
            end
            res.norm = r[31:0];
        end else begin
            c64 = cur_cos;
            s64 = cur_sin;
            res.rot_a = round_sat(c64 * a64 + s64 * b64);
            res.rot_b = round_sat(c64 * b64 - s64 * a64);
        end
        res.cos_q30 = cur_cos;
        res.sin_q30 = cur_sin;
        return res;
    endfunction

    function automatic t_sword rand_operand();
        case ($urandom_range(0, 9))
            0:       return SAT_NEG;
            1:       return SAT_POS;
            2:       return '0;
            3, 4:    return $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
            5:       return $signed($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 5;
            2:       return 20;
            default: return 50;
        endcase
    endfunction

    task automatic send_item(logic op, t_sword a, t_sword b, logic known,
                             t_rot_res typed_res);
        t_rot_res pred;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        do @(posedge i_clk); while (!o_in_ready);
        pred = predict_rotation(op, a, b);
        pending_rotations.push_back(known ? typed_res : pred);
        n_accepted++;
    endtask

    initial begin
        logic op;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_operation <= OP_GEN;
        i_operand_a <= '0;
        i_operand_b <= '0;
        n_fail      = 0;
        n_accepted  = 0;
        gap_pct     = 10;
        stall_pct   = 10;
        cur_cos     = ONE_Q30;
        cur_sin     = '0;

        // identity rotation out of reset
        stim_rows.push_back('{OP_APPLY, 32'sh1_0000, -32'sh1_0000, 1'b1,
                              '{'0, ONE_Q30, '0, 32'sh1_0000, -32'sh1_0000}});
        stim_rows.push_back('{OP_APPLY, SAT_NEG, SAT_POS, 1'b1,
                              '{'0, ONE_Q30, '0, SAT_NEG, SAT_POS}});
        // zero pair
        stim_rows.push_back('{OP_GEN, '0, '0, 1'b1, '{'0, ONE_Q30, '0, '0, '0}});
        stim_rows.push_back('{OP_GEN, 32'sh3_0000, 32'sh4_0000, 1'b0, NO_RES});
        stim_rows.push_back('{OP_APPLY, 32'sh3_0000, 32'sh4_0000, 1'b0, NO_RES});
        // most negative operands
        stim_rows.push_back('{OP_GEN, SAT_NEG, '0, 1'b1,
                              '{32'h8000_0000, -ONE_Q30, '0, '0, '0}});
        stim_rows.push_back('{OP_APPLY, SAT_POS, '0, 1'b1,
                              '{'0, -ONE_Q30, '0, 32'sh8000_0001, '0}});
        stim_rows.push_back('{OP_GEN, '0, SAT_NEG, 1'b1,
                              '{32'h8000_0000, '0, -ONE_Q30, '0, '0}});
        stim_rows.push_back('{OP_APPLY, '0, SAT_NEG, 1'b1,
                              '{'0, '0, -ONE_Q30, SAT_POS, '0}});
        stim_rows.push_back('{OP_APPLY, SAT_NEG, '0, 1'b1,
                              '{'0, '0, -ONE_Q30, '0, SAT_NEG}});
        stim_rows.push_back('{OP_GEN, SAT_POS, SAT_POS, 1'b0, NO_RES});
        stim_rows.push_back('{OP_GEN, SAT_NEG, SAT_NEG, 1'b0, NO_RES});
        stim_rows.push_back('{OP_APPLY, SAT_POS, SAT_NEG, 1'b0, NO_RES});
        // smallest nonzero pairs
        stim_rows.push_back('{OP_GEN, 32'sd1, '0, 1'b1, '{32'd1, ONE_Q30, '0, '0, '0}});
        stim_rows.push_back('{OP_GEN, '0, -32'sd1, 1'b1,
                              '{32'd1, '0, -ONE_Q30, '0, '0}});
        stim_rows.push_back('{OP_APPLY, 32'sd1, 32'sd1, 1'b1,
                              '{'0, '0, -ONE_Q30, -32'sd1, 32'sd1}});
        stim_rows.push_back('{OP_GEN, 32'sd1, 32'sd1, 1'b1,
                              '{32'd1, ONE_Q30, ONE_Q30, '0, '0}});
        // saturation both ways
        stim_rows.push_back('{OP_APPLY, SAT_POS, SAT_POS, 1'b1,
                              '{'0, ONE_Q30, ONE_Q30, SAT_POS, '0}});
        stim_rows.push_back('{OP_APPLY, SAT_NEG, SAT_NEG, 1'b1,
                              '{'0, ONE_Q30, ONE_Q30, SAT_NEG, '0}});
        stim_rows.push_back('{OP_GEN, 32'sh8000, 32'sh8000, 1'b0, NO_RES});
        stim_rows.push_back('{OP_GEN, -32'sh1_2345, 32'sh6_789A, 1'b0, NO_RES});
        stim_rows.push_back('{OP_APPLY, -32'sd1, 32'sd1, 1'b0, NO_RES});
        // zero pair restores identity
        stim_rows.push_back('{OP_GEN, '0, '0, 1'b1, '{'0, ONE_Q30, '0, '0, '0}});
        stim_rows.push_back('{OP_APPLY, 32'sd5, -32'sd7, 1'b1,
                              '{'0, ONE_Q30, '0, 32'sd5, -32'sd7}});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[i])
            send_item(stim_rows[i].op, stim_rows[i].a, stim_rows[i].b,
                      stim_rows[i].known, stim_rows[i].res);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % CHUNK_ITEMS == 0) begin
                gap_pct   = pick_idle_pct();
                stall_pct = pick_idle_pct();
            end
            if (i >= RANDOM_ITEMS - QUIET_TAIL) begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            op = ($urandom_range(0, 2) == 0) ? OP_GEN : OP_APPLY;
            send_item(op, rand_operand(), rand_operand(), 1'b0, NO_RES);
        end
        i_in_valid <= 1'b0;

        while (pending_rotations.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_fail == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // output side: random stalls, one long hold-off to back up the input
    initial begin
        int hold_cnt;
        i_out_ready <= 1'b0;
        hold_done   = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!hold_done && n_accepted >= HOLD_AFTER) begin
                hold_done = 1'b1;
                i_out_ready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
                    @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_rotations.size() == 0) begin
                $error("output transfer with no expected result");
                n_fail++;
            end else begin
                want = pending_rotations.pop_front();
                if (o_rot_norm !== want.norm) begin
                    $error("rot_norm: expected %0d, got %0d", want.norm, o_rot_norm);
                    n_fail++;
                end
                if (o_cos_value !== want.cos_q30) begin
                    $error("cos_value: expected %0d, got %0d", want.cos_q30, o_cos_value);
                    n_fail++;
                end
                if (o_sin_value !== want.sin_q30) begin
                    $error("sin_value: expected %0d, got %0d", want.sin_q30, o_sin_value);
                    n_fail++;
                end
                if (o_new_a !== want.rot_a) begin
                    $error("new_a: expected %0d, got %0d", want.rot_a, o_new_a);
                    n_fail++;
                end
                if (o_new_b !== want.rot_b) begin
                    $error("new_b: expected %0d, got %0d", want.rot_b, o_new_b);
                    n_fail++;
                end
            end
        end
    end

    initial n_cycles = 0;
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
